// ----- hw/rtl/serial_frame_parser_unit_defines.svh -----
// assertion helpers used by the checker file
`ifndef SERIAL_FRAME_PARSER_UNIT_DEFINES_SVH
`define SERIAL_FRAME_PARSER_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sfp_pkg.sv -----
`timescale 1ns / 1ps

package sfp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] TYPE_BYTE   = 8'h03;
  localparam logic [7:0] OFFSET_BYTE = 8'h02;
  localparam logic [7:0] LEN_BYTE    = 8'h06;

  localparam int PAYLOAD_LEN      = 6;
  localparam int PAYLOAD_IDX_W    = $clog2(PAYLOAD_LEN);
  localparam int SYNC_RUN_W       = 3;
  localparam int SYNC_RUN_LEN_DEF = 4;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int FRAME_CNT_W      = 16;
  localparam int OUT_DATA_W       = 88;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_OFFSET,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  // result word as carried on tdata, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]             pad;
    logic [FRAME_CNT_W-1:0] bad_frames;
    logic [FRAME_CNT_W-1:0] good_frames;
    logic signed [31:0]     cycle_value;
    logic signed [15:0]     pulse_value;
    logic                   checksum_ok;
  } result_t;

  // xor of the sync run followed by type, offset and length
  function automatic logic [7:0] prefix_xor(input int run_len);
    logic [7:0] x;
    int         k;
    x = 8'h00;
    for (k = 0; k < run_len; k++) begin
      x = x ^ SYNC_BYTE;
    end
    return x ^ TYPE_BYTE ^ OFFSET_BYTE ^ LEN_BYTE;
  endfunction

endpackage

// ----- hw/rtl/serial_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// serial frame parser
// in_* channel: one received byte per request on in_tdata[7:0]. a run of
// SYNC_RUN_LENGTH bytes of 0xaa starts a frame anywhere in the stream; then
// type 0x03, offset 0x02, length 0x06, six payload bytes and a check byte
// (xor of all frame bytes) must follow.
// out_* channel: one request per check byte: checksum flag, pulse and cycle
// latches, good and bad frame counts (low 16 bits).
// the result is registered (output register, or skid slot while stalled).
// throughput: one byte per cycle while in_tready is high, every byte handled
// in one pass of logic from the parser state registers to the output register.
// stall: an output register plus one skid slot hold results; in_tready only
// drops when both are full, i.e. out_tready held low across two results.
// reset: parser hunts for a header, latches and counters clear, no result
// is pending. the payload bytes are not cleared.
module serial_frame_parser_unit
  import sfp_pkg::*;
#(
  parameter int SYNC_RUN_LENGTH = SYNC_RUN_LEN_DEF,
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // checksum_ok, pulse_value, cycle_value, good_frames, bad_frames, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [SYNC_RUN_W-1:0]    RUN_DONE   = SYNC_RUN_W'(SYNC_RUN_LENGTH);
  localparam logic [7:0]               PREFIX_XOR = prefix_xor(SYNC_RUN_LENGTH);
  localparam logic [PAYLOAD_IDX_W-1:0] IDX_END    = PAYLOAD_IDX_W'(PAYLOAD_LEN);

  phase_t                    phase_r, phase_nxt;
  logic [SYNC_RUN_W-1:0]     sync_run_r, sync_run_nxt, run_inc;
  logic [PAYLOAD_IDX_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [7:0]                xor_r, xor_nxt;
  logic [7:0]                store_r [PAYLOAD_LEN];
  logic signed [15:0]        pulse_r, pulse_nxt;
  logic signed [31:0]        cycle_r, cycle_nxt;
  logic [COUNT_WIDTH-1:0]    good_cnt_r, good_cnt_nxt;
  logic [COUNT_WIDTH-1:0]    bad_cnt_r, bad_cnt_nxt;
  logic                      out_valid_r, skid_valid_r;
  result_t                   out_data_r, skid_data_r, res;
  logic                      in_fire, out_pop, hdr_done, chk_ok, res_push, store_we;

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_pop    = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign run_inc  = (in_tdata == SYNC_BYTE) ? SYNC_RUN_W'(sync_run_r + 1'b1) : '0;
  assign hdr_done = (run_inc == RUN_DONE);
  assign idx_inc  = PAYLOAD_IDX_W'(idx_r + 1'b1);
  assign chk_ok   = (xor_r == in_tdata);
  assign store_we = in_fire && !hdr_done && (phase_r == PH_DATA) && (idx_r < IDX_END);

  always_comb begin
    sync_run_nxt = sync_run_r;
    if (in_fire) begin
      sync_run_nxt = hdr_done ? '0 : run_inc;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      if (hdr_done) begin
        phase_nxt = PH_TYPE;
      end else begin
        case (phase_r)
          PH_TYPE:   phase_nxt = (in_tdata == TYPE_BYTE) ? PH_OFFSET : PH_HUNT;
          PH_OFFSET: phase_nxt = (in_tdata == OFFSET_BYTE) ? PH_LEN : PH_HUNT;
          PH_LEN:    phase_nxt = (in_tdata == LEN_BYTE) ? PH_DATA : PH_HUNT;
          PH_DATA:   phase_nxt = (idx_inc >= IDX_END) ? PH_CHECK : PH_DATA;
          PH_CHECK:  phase_nxt = PH_HUNT;
          default:   phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    idx_nxt      = idx_r;
    xor_nxt      = xor_r;
    pulse_nxt    = pulse_r;
    cycle_nxt    = cycle_r;
    good_cnt_nxt = good_cnt_r;
    bad_cnt_nxt  = bad_cnt_r;
    res_push     = 1'b0;
    if (in_fire && !hdr_done) begin
      case (phase_r)
        PH_LEN: begin
          if (in_tdata == LEN_BYTE) begin
            idx_nxt = '0;
            xor_nxt = PREFIX_XOR;
          end
        end
        PH_DATA: begin
          idx_nxt = idx_inc;
          xor_nxt = xor_r ^ in_tdata;
        end
        PH_CHECK: begin
          res_push = 1'b1;
          if (chk_ok) begin
            pulse_nxt    = $signed({store_r[1], store_r[0]});
            cycle_nxt    = $signed({store_r[5], store_r[4], store_r[3], store_r[2]});
            good_cnt_nxt = COUNT_WIDTH'(good_cnt_r + 1'b1);
          end else begin
            bad_cnt_nxt = COUNT_WIDTH'(bad_cnt_r + 1'b1);
          end
        end
        default: ;
      endcase
    end
    res.pad         = '0;
    res.checksum_ok = chk_ok;
    res.pulse_value = pulse_nxt;
    res.cycle_value = cycle_nxt;
    res.good_frames = FRAME_CNT_W'(good_cnt_nxt);
    res.bad_frames  = FRAME_CNT_W'(bad_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      sync_run_r <= '0;
      idx_r      <= '0;
      xor_r      <= '0;
      pulse_r    <= '0;
      cycle_r    <= '0;
      good_cnt_r <= '0;
      bad_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      sync_run_r <= sync_run_nxt;
      idx_r      <= idx_nxt;
      xor_r      <= xor_nxt;
      pulse_r    <= pulse_nxt;
      cycle_r    <= cycle_nxt;
      good_cnt_r <= good_cnt_nxt;
      bad_cnt_r  <= bad_cnt_nxt;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (out_valid_r && !out_pop) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_push) begin
      if (out_valid_r && !out_pop) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

endmodule

// ----- hw/rtl/sfp_checker.sv -----
`timescale 1ns / 1ps
`include "serial_frame_parser_unit_defines.svh"

module sfp_checker
  import sfp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  result_t                res;
  logic                   out_fire, out_stall, good_match, bad_match;
  logic [FRAME_CNT_W-1:0] prev_good_r, prev_bad_r, good_inc, bad_inc;
  logic signed [15:0]     prev_pulse_r;
  logic signed [31:0]     prev_cycle_r;

  assign res       = out_tdata;
  assign out_fire  = out_tvalid && out_tready;
  assign out_stall = out_tvalid && !out_tready;
  // counters wrap at their own width, seen through the 16-bit field
  assign good_inc = FRAME_CNT_W'(COUNT_WIDTH'(prev_good_r + 1'b1));
  assign bad_inc  = FRAME_CNT_W'(COUNT_WIDTH'(prev_bad_r + 1'b1));

  assign good_match = (res.good_frames == good_inc) && (res.bad_frames == prev_bad_r);
  assign bad_match  = (res.bad_frames == bad_inc) && (res.good_frames == prev_good_r) &&
                      (res.pulse_value == prev_pulse_r) && (res.cycle_value == prev_cycle_r);

  // last delivered result, starting from the reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_good_r  <= '0;
      prev_bad_r   <= '0;
      prev_pulse_r <= '0;
      prev_cycle_r <= '0;
    end else if (out_fire) begin
      prev_good_r  <= res.good_frames;
      prev_bad_r   <= res.bad_frames;
      prev_pulse_r <= res.pulse_value;
      prev_cycle_r <= res.cycle_value;
    end
  end

  `SFP_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "stalled result moved")

  `SFP_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready, "input stalled while empty")

  `SFP_ASSERT_SAME(a_good_step, out_fire && res.checksum_ok, good_match, "good count did not step")

  `SFP_ASSERT_SAME(a_bad_step, out_fire && !res.checksum_ok, bad_match, "bad frame moved latches")

endmodule

bind serial_frame_parser_unit sfp_checker #(
  .COUNT_WIDTH(COUNT_WIDTH)
) u_sfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/serial_frame_parser_unit_tb.sv -----
`timescale 1ns / 1ps

module serial_frame_parser_unit_tb;
  import sfp_pkg::*;

  localparam int HALF_PERIOD       = 6;
  localparam int RESET_CYCLES      = 8;
  localparam int RANDOM_BYTES      = 600;
  localparam int HOLD_CYCLES       = 500;
  localparam int HOLD_AFTER        = 6;
  localparam int IDLE_LIMIT        = 4000;
  localparam int DRAIN_CYCLES      = 8;
  localparam int PRINT_CAP         = 60;

  // an even run of sync bytes cancels out of the frame xor
  localparam logic [7:0] HEADER_XOR = ((SYNC_RUN_LEN_DEF % 2) ? SYNC_BYTE : 8'h00) ^
                                      TYPE_BYTE ^ OFFSET_BYTE ^ LEN_BYTE;

  typedef struct packed {
    logic [7:0] rx;
    logic       fixed;
    result_t    want;
  } rx_row_t;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_THIRD,
    SINK_MOSTLY
  } sink_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  rx_row_t rx_feed[$];
  rx_row_t cur_row;
  result_t frame_reports_q[$];

  int directed_rows   = 0;
  int bytes_taken     = 0;
  int reports_seen    = 0;
  int mismatches      = 0;
  int in_stall_cycles = 0;
  int idle_cycles     = 0;

  // parser model state
  phase_t      frame_phase;
  logic [2:0]  hdr_run;
  logic [7:0]  pay_bytes [PAYLOAD_LEN];
  logic [2:0]  pay_idx;
  logic [7:0]  frame_xor;
  logic [15:0] pulse_hold;
  logic [31:0] cycle_hold;
  logic [15:0] good_cnt;
  logic [15:0] bad_cnt;

  serial_frame_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  task automatic parse_rx_byte(input logic [7:0] rx, output bit emits, output result_t rep);
    bit ok;
    emits = 1'b0;
    rep   = '0;
    if (rx == SYNC_BYTE) begin
      hdr_run = hdr_run + 3'd1;
    end else begin
      hdr_run = 3'd0;
    end
    if (hdr_run == 3'(SYNC_RUN_LEN_DEF)) begin
      // a full sync run restarts the frame whatever phase we are in
      hdr_run     = 3'd0;
      frame_phase = PH_TYPE;
    end else begin
      case (frame_phase)
        PH_TYPE: begin
          if (rx == TYPE_BYTE) frame_phase = PH_OFFSET;
          else frame_phase = PH_HUNT;
        end
        PH_OFFSET: begin
          if (rx == OFFSET_BYTE) frame_phase = PH_LEN;
          else frame_phase = PH_HUNT;
        end
        PH_LEN: begin
          if (rx == LEN_BYTE) begin
            frame_phase = PH_DATA;
            pay_idx     = 3'd0;
            frame_xor   = HEADER_XOR;
          end else begin
            frame_phase = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (pay_idx < PAYLOAD_LEN) pay_bytes[pay_idx] = rx;
          frame_xor = frame_xor ^ rx;
          pay_idx   = pay_idx + 3'd1;
          if (pay_idx >= PAYLOAD_LEN) frame_phase = PH_CHECK;
        end
        PH_CHECK: begin
          ok = (frame_xor == rx);
          if (ok) begin
            pulse_hold = {pay_bytes[1], pay_bytes[0]};
            cycle_hold = {pay_bytes[5], pay_bytes[4], pay_bytes[3], pay_bytes[2]};
            good_cnt   = good_cnt + 16'd1;
          end else begin
            bad_cnt = bad_cnt + 16'd1;
          end
          frame_phase     = PH_HUNT;
          emits           = 1'b1;
          rep.checksum_ok = ok;
          rep.pulse_value = pulse_hold;
          rep.cycle_value = cycle_hold;
          rep.good_frames = good_cnt;
          rep.bad_frames  = bad_cnt;
        end
        default: frame_phase = PH_HUNT;
      endcase
    end
  endtask

  function automatic result_t frame_report(bit ok, logic [15:0] pulse, logic [31:0] cyc,
                                           logic [15:0] good, logic [15:0] bad);
    result_t r;
    r             = '0;
    r.checksum_ok = ok;
    r.pulse_value = pulse;
    r.cycle_value = cyc;
    r.good_frames = good;
    r.bad_frames  = bad;
    return r;
  endfunction

  function automatic logic [7:0] not_sync(logic [7:0] v);
    return (v == SYNC_BYTE) ? (v ^ 8'h11) : v;
  endfunction

  task automatic push_rx_fixed(input logic [7:0] rx, input result_t want);
    rx_row_t r;
    r.rx    = rx;
    r.fixed = 1'b1;
    r.want  = want;
    rx_feed.push_back(r);
  endtask

  task automatic push_rx(input logic [7:0] rx);
    rx_row_t r;
    r.rx    = rx;
    r.fixed = 1'b0;
    r.want  = '0;
    rx_feed.push_back(r);
  endtask

  task automatic push_header();
    repeat (SYNC_RUN_LEN_DEF) push_rx(SYNC_BYTE);
  endtask

  task automatic push_prefix();
    push_rx(TYPE_BYTE);
    push_rx(OFFSET_BYTE);
    push_rx(LEN_BYTE);
  endtask

  // type, offset, length, payload and check byte
  task automatic push_body(input bit corrupt, input bit extreme);
    logic [7:0] pay [PAYLOAD_LEN];
    logic [7:0] x;
    logic [7:0] chk;
    int         pick;
    int         k;
    pick = $urandom_range(0, 3);
    for (k = 0; k < PAYLOAD_LEN; k++) begin
      if (extreme) begin
        case (pick)
          0: pay[k] = 8'h00;
          1: pay[k] = 8'hFF;
          2: pay[k] = (k == 1 || k == 5) ? 8'h80 : 8'h00;
          default: pay[k] = (k == 1 || k == 5) ? 8'h7F : 8'hFF;
        endcase
      end else begin
        pay[k] = ($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255));
      end
    end
    push_prefix();
    x = HEADER_XOR;
    for (k = 0; k < PAYLOAD_LEN; k++) begin
      push_rx(pay[k]);
      x = x ^ pay[k];
    end
    chk = x;
    if (corrupt) begin
      chk = x ^ 8'($urandom_range(1, 255));
      // keep a stray sync byte from eating into the next header
      while (chk == SYNC_BYTE || chk == x) chk = x ^ 8'($urandom_range(1, 255));
    end
    push_rx(chk);
  endtask

  task automatic build_random_feed();
    int         mode;
    int         n;
    int         start;
    logic [7:0] v;
    logic [7:0] wanted;
    start = rx_feed.size();
    while ((rx_feed.size() - start) < RANDOM_BYTES) begin
      mode = $urandom_range(0, 99);
      if (mode < 50) begin
        push_header();
        push_body(1'b0, 1'b0);
      end else if (mode < 64) begin
        push_header();
        push_body(1'b1, 1'b0);
      end else if (mode < 72) begin
        // header then a rejected type, offset or length
        push_header();
        n = $urandom_range(0, 2);
        if (n > 0) push_rx(TYPE_BYTE);
        if (n > 1) push_rx(OFFSET_BYTE);
        wanted = (n == 0) ? TYPE_BYTE : (n == 1) ? OFFSET_BYTE : LEN_BYTE;
        v = not_sync(8'($urandom_range(0, 255)));
        if (v == wanted) v = v ^ 8'h40;
        push_rx(v);
      end else if (mode < 80) begin
        // new header lands in the middle of the payload
        push_header();
        push_prefix();
        n = $urandom_range(0, PAYLOAD_LEN - 1);
        repeat (n) push_rx(8'($urandom_range(0, 255)));
        push_header();
        push_body(1'b0, 1'b0);
      end else if (mode < 86) begin
        // last three payload bytes and the check byte form a sync run
        push_header();
        push_prefix();
        repeat (PAYLOAD_LEN - 3) push_rx(not_sync(8'($urandom_range(0, 255))));
        push_header();
        push_body(1'b0, 1'b0);
      end else if (mode < 94) begin
        n = $urandom_range(1, 8);
        repeat (n - 1) begin
          push_rx(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
        end
        push_rx(not_sync(8'($urandom_range(0, 255))));
      end else begin
        push_header();
        push_body(1'b0, 1'b1);
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t ns: %s got %0h expected %0h (report %0d)", $time, what, got_v, want_v,
               reports_seen);
    end
  endtask

  // stimulus: directed frames first, then the random stream
  initial begin : stimulus
    int row_i;
    int burst_left;
    int gap;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    cur_row     = '0;
    frame_phase = PH_HUNT;
    hdr_run     = 3'd0;
    pay_idx     = 3'd0;
    frame_xor   = 8'h00;
    pulse_hold  = 16'h0000;
    cycle_hold  = 32'h0000_0000;
    good_cnt    = 16'd0;
    bad_cnt     = 16'd0;
    for (row_i = 0; row_i < PAYLOAD_LEN; row_i++) pay_bytes[row_i] = 8'h00;

    // frame with sync bytes in the payload and a wrong check byte
    push_header();
    push_prefix();
    push_rx(SYNC_BYTE);
    push_rx(SYNC_BYTE);
    push_rx(SYNC_BYTE);
    push_rx(8'h55);
    push_rx(8'h00);
    push_rx(8'h00);
    push_rx_fixed(8'h00, frame_report(1'b0, 16'h0000, 32'h0000_0000, 16'd0, 16'd1));
    // good frame with most negative pulse and most positive cycle
    push_header();
    push_prefix();
    push_rx(8'h00);
    push_rx(8'h80);
    push_rx(8'hFF);
    push_rx(8'hFF);
    push_rx(8'hFF);
    push_rx(8'h7F);
    push_rx_fixed(HEADER_XOR, frame_report(1'b1, 16'h8000, 32'h7FFF_FFFF, 16'd1, 16'd1));
    directed_rows = rx_feed.size();
    build_random_feed();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    for (row_i = 0; row_i < rx_feed.size(); row_i++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      in_tvalid <= 1'b1;
      in_tdata  <= rx_feed[row_i].rx;
      cur_row   <= rx_feed[row_i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;

    while (frame_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d bytes taken (%0d directed), %0d frame reports checked",
             bytes_taken, directed_rows, reports_seen);
    $display("run: output held off %0d cycles once, input back-pressured on %0d cycles",
             HOLD_CYCLES, in_stall_cycles);
    if (mismatches == 0) begin
      $display("serial_frame_parser_unit: match");
    end else begin
      $display("serial_frame_parser_unit: mismatch");
    end
    $finish;
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin : sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         tick;
    bit         held;
    out_tready = 1'b0;
    mode       = SINK_OPEN;
    mode_left  = 50;
    hold_left  = 0;
    tick       = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!held && reports_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:  out_tready <= 1'b1;
          SINK_COIN:  out_tready <= 1'($urandom_range(0, 1));
          SINK_THIRD: out_tready <= (tick % 3 == 0);
          default:    out_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    result_t predicted;
    bit      emits;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        reports_seen++;
        if (frame_reports_q.size() == 0) begin
          flag_mismatch("report with none pending, good_frames", 32'(got.good_frames), 32'd0);
        end else begin
          want = frame_reports_q.pop_front();
          if (got.checksum_ok !== want.checksum_ok)
            flag_mismatch("checksum_ok", 32'(got.checksum_ok), 32'(want.checksum_ok));
          if (got.pulse_value !== want.pulse_value)
            flag_mismatch("pulse_value", 32'(got.pulse_value), 32'(want.pulse_value));
          if (got.cycle_value !== want.cycle_value)
            flag_mismatch("cycle_value", got.cycle_value, want.cycle_value);
          if (got.good_frames !== want.good_frames)
            flag_mismatch("good_frames", 32'(got.good_frames), 32'(want.good_frames));
          if (got.bad_frames !== want.bad_frames)
            flag_mismatch("bad_frames", 32'(got.bad_frames), 32'(want.bad_frames));
          if (got.pad !== want.pad)
            flag_mismatch("pad bits", 32'(got.pad), 32'(want.pad));
        end
      end
      // the report for a byte taken now cannot leave before the next edge
      if (in_tvalid && in_tready) begin
        parse_rx_byte(in_tdata, emits, predicted);
        bytes_taken++;
        if (emits) frame_reports_q.push_back(cur_row.fixed ? cur_row.want : predicted);
      end
      if (in_tvalid && !in_tready) in_stall_cycles++;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  always @(negedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports still pending",
               idle_cycles, frame_reports_q.size());
      $display("serial_frame_parser_unit: mismatch");
      $finish;
    end
  end

endmodule
